@@ hdl/gcpp_pkg.sv @@
// ----------------------------------------------------------------------------
// gcpp_pkg
// types, codes and decode helpers shared by the command packet parser
// ----------------------------------------------------------------------------
package gcpp_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] TERM_MASK  = 32'hF000_F000;
  localparam logic [31:0] TERM_VALUE = 32'h5000_5000;

  typedef enum logic [3:0] {
    ROLE_IDLE     = 4'd0,
    ROLE_CMD      = 4'd1,
    ROLE_COLOR    = 4'd2,
    ROLE_VERTEX   = 4'd3,
    ROLE_TEX_CLUT = 4'd4,
    ROLE_TEX_PAGE = 4'd5,
    ROLE_TEX      = 4'd6,
    ROLE_TERM     = 4'd7,
    ROLE_SETTING  = 4'd8,
    ROLE_NOP      = 4'd9,
    ROLE_IRQ      = 4'd10,
    ROLE_INVALID  = 4'd11
  } role_t;

  typedef enum logic [1:0] {
    PRIM_TRI  = 2'd0,
    PRIM_QUAD = 2'd1,
    PRIM_LINE = 2'd2,
    PRIM_POLY = 2'd3
  } prim_t;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_IRQ,
    KIND_SET,
    KIND_PRIM,
    KIND_BAD
  } kind_t;

  typedef enum logic {
    PS_IDLE,
    PS_COLLECT
  } ps_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RESET = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  word_role;
    logic [1:0]  primitive_res;
    logic        gouraud;
    logic        textured;
    logic        raw_texture;
    logic        semi_transparent;
    logic [3:0]  vertex_number;
    logic [31:0] payload;
    logic [2:0]  setting_target;
    logic        packet_end;
  } res_t;

  // classified item between front and back
  typedef struct packed {
    logic        op;
    logic [31:0] word;
    kind_t       kind;
    logic        term;
  } item_t;

  typedef struct packed {
    role_t role;
    logic  closes;
  } role_info_t;

  function automatic logic is_textured(input logic [7:0] c);
    return (c < 8'h40) && c[2];
  endfunction

  function automatic logic is_polyline(input logic [7:0] c);
    return (c >= 8'h40) && c[3];
  endfunction

  function automatic prim_t prim_kind(input logic [7:0] c);
    if (c < 8'h40) return c[3] ? PRIM_QUAD : PRIM_TRI;
    return c[3] ? PRIM_POLY : PRIM_LINE;
  endfunction

  function automatic logic [4:0] packet_len(input logic [7:0] c);
    logic [4:0] n;
    n = (c >= 8'h40) ? 5'd2 : (c[3] ? 5'd4 : 5'd3);
    if (!c[4]) return is_textured(c) ? 5'((n << 1) + 5'd1) : 5'(n + 5'd1);
    return is_textured(c) ? 5'(n * 5'd3) : 5'(n << 1);
  endfunction

  function automatic logic [1:0] mod3(input logic [3:0] v);
    case (v)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: return 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       return 2'd1;
      default:                              return 2'd2;
    endcase
  endfunction

  // role of packet word idx and whether it closes a vertex group
  function automatic role_info_t role_of(input logic [7:0] c, input logic [4:0] idx);
    role_info_t r;
    logic [4:0] j;
    r.role   = ROLE_CMD;
    r.closes = 1'b0;
    j        = 5'(idx - 5'd1);
    if (idx == 5'd0) begin
      r.role = ROLE_CMD;
    end else if (!c[4]) begin
      if (!is_textured(c)) begin
        r.role   = ROLE_VERTEX;
        r.closes = 1'b1;
      end else if (!j[0]) begin
        r.role = ROLE_VERTEX;
      end else begin
        r.closes = 1'b1;
        r.role   = (j == 5'd1) ? ROLE_TEX_CLUT : ((j == 5'd3) ? ROLE_TEX_PAGE : ROLE_TEX);
      end
    end else if (!is_textured(c)) begin
      if (!idx[0]) begin
        r.role = ROLE_COLOR;
      end else begin
        r.role   = ROLE_VERTEX;
        r.closes = 1'b1;
      end
    end else begin
      case (mod3(idx[3:0]))
        2'd0: r.role = ROLE_COLOR;
        2'd1: r.role = ROLE_VERTEX;
        default: begin
          r.closes = 1'b1;
          r.role   = (idx == 5'd2) ? ROLE_TEX_CLUT :
                     ((idx == 5'd5) ? ROLE_TEX_PAGE : ROLE_TEX);
        end
      endcase
    end
    return r;
  endfunction

endpackage

@@ hdl/gcpp_front.sv @@
// ----------------------------------------------------------------------------
// gcpp_front
// input stage: registers each port word and classifies its top byte
// ----------------------------------------------------------------------------
module gcpp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  gcpp_pkg::cmd_t cmd,
  output logic          item_valid,
  input  logic          item_ready,
  output gcpp_pkg::item_t item
);
  import gcpp_pkg::*;

  kind_t kind;

  always_comb begin
    unique case (cmd.word[31:24]) inside
      8'h00:                                  kind = KIND_NOP;
      8'h1F:                                  kind = KIND_IRQ;
      [8'hE1:8'hE6]:                          kind = KIND_SET;
      [8'h20:8'h3F], 8'h40, 8'h42, 8'h48,
      8'h4A, 8'h50, 8'h52, 8'h58:             kind = KIND_PRIM;
      default:                                kind = KIND_BAD;
    endcase
  end

  assign cmd_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd_ready) begin
      item_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      item.op   <= cmd.op;
      item.word <= cmd.word;
      item.kind <= kind;
      item.term <= (cmd.word & TERM_MASK) == TERM_VALUE;
    end
  end

endmodule

@@ hdl/gcpp_queue.sv @@
// ----------------------------------------------------------------------------
// gcpp_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module gcpp_queue #(
  parameter int Depth = gcpp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  gcpp_pkg::item_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gcpp_pkg::item_t pop_data
);
  import gcpp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = count != CntW'(Depth);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= CntW'(count + 1'b1);
      else if (pop && !push) count <= CntW'(count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CntW'($past(count) + 1'b1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == CntW'($past(count) - 1'b1))
    else $error("queue count missed a pop");
`endif

endmodule

@@ hdl/gcpp_back.sv @@
// ----------------------------------------------------------------------------
// gcpp_back
// packet tracker: tags each word and holds the result in an output register
// ----------------------------------------------------------------------------
module gcpp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  gcpp_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_ready,
  output gcpp_pkg::res_t  res
);
  import gcpp_pkg::*;

  ps_t        state;
  ps_t        state_next;
  logic [7:0] current_opcode;
  logic [7:0] current_opcode_next;
  logic [4:0] words_taken;
  logic [4:0] words_taken_next;
  logic [3:0] vertex_count;
  logic [3:0] vertex_count_next;
  res_t       res_next;
  logic       take;

  logic [7:0]  c;
  logic [4:0]  idx;
  logic [3:0]  vc;
  role_info_t  ri;

  assign item_ready = !res_valid || res_ready;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= PS_IDLE;
      current_opcode <= '0;
      words_taken    <= '0;
      vertex_count   <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (take) begin
        state          <= state_next;
        current_opcode <= current_opcode_next;
        words_taken    <= words_taken_next;
        vertex_count   <= vertex_count_next;
      end
      if (item_ready) res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

  always_comb begin
    c   = (state == PS_IDLE) ? item.word[31:24] : current_opcode;
    idx = (state == PS_IDLE) ? 5'd0 : words_taken;
    vc  = (state == PS_IDLE) ? 4'd0 : vertex_count;
    ri  = role_of(c, idx);

    state_next          = state;
    current_opcode_next = current_opcode;
    words_taken_next    = words_taken;
    vertex_count_next   = vertex_count;
    res_next            = '0;

    if (item.op == OP_RESET) begin
      state_next          = PS_IDLE;
      current_opcode_next = '0;
      words_taken_next    = '0;
      vertex_count_next   = '0;
    end else if (state == PS_IDLE && item.kind != KIND_PRIM) begin
      res_next.payload    = item.word;
      res_next.packet_end = 1'b1;
      unique case (item.kind)
        KIND_NOP: res_next.word_role = ROLE_NOP;
        KIND_IRQ: res_next.word_role = ROLE_IRQ;
        KIND_SET: begin
          res_next.word_role      = ROLE_SETTING;
          res_next.payload        = {8'h00, item.word[23:0]};
          res_next.setting_target = 3'(item.word[26:24] - 3'd1);
        end
        default: res_next.word_role = ROLE_INVALID;
      endcase
    end else begin
      res_next.primitive_res    = prim_kind(c);
      res_next.gouraud          = c[4];
      res_next.textured         = is_textured(c);
      res_next.raw_texture      = is_textured(c) && c[0];
      res_next.semi_transparent = c[1];
      res_next.vertex_number    = vc;
      res_next.payload          = item.word;
      current_opcode_next       = c;
      state_next                = PS_COLLECT;
      vertex_count_next         = (ri.closes && vc != 4'd15) ? 4'(vc + 4'd1) : vc;
      if (is_polyline(c) && idx >= 5'd3 && item.term) begin
        res_next.word_role  = ROLE_TERM;
        res_next.packet_end = 1'b1;
        state_next          = PS_IDLE;
        words_taken_next    = '0;
        vertex_count_next   = '0;
      end else if (is_polyline(c)) begin
        res_next.word_role = ri.role;
        words_taken_next   = (idx == 5'd31) ? 5'd30 : 5'(idx + 5'd1);
      end else begin
        res_next.word_role = ri.role;
        if (5'(idx + 5'd1) >= packet_len(c)) begin
          res_next.packet_end = 1'b1;
          state_next          = PS_IDLE;
          words_taken_next    = '0;
          vertex_count_next   = '0;
        end else begin
          words_taken_next = 5'(idx + 5'd1);
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    state == PS_IDLE |-> words_taken == '0 && vertex_count == '0)
    else $error("packet counters not clear while idle");

  a_reset_item: assert property (@(posedge clk) disable iff (rst)
    take && item.op == OP_RESET |=> res_valid && res == '0 && state == PS_IDLE)
    else $error("reset item did not drop packet");

  a_term_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.word_role == ROLE_TERM |->
      res.packet_end && res.primitive_res == PRIM_POLY)
    else $error("terminator outside polyline");
`endif

endmodule

@@ hdl/gpu_command_packet_parser.sv @@
// ----------------------------------------------------------------------------
// gpu_command_packet_parser
// tags every command-port word with its role inside a drawing packet
// ----------------------------------------------------------------------------
// cmd channel: one transfer per port word (op 0) or parser reset (op 1)
// res channel: exactly one result per cmd transfer, in order
// path: a word transferred on the cmd channel passes the input register, the queue
//   and the output register before its result is offered
// throughput: one word per cycle while the receiver takes results; the packet state
//   lives in one register set updated once per word in the back stage
// a stalled receiver holds the output register; the queue and input register
//   keep absorbing words until they fill, then cmd_ready drops
// rst clears all valid flags and the packet state; no clearing pass follows
// a reset item drops a partial packet and returns an all-zero result
// ----------------------------------------------------------------------------
module gpu_command_packet_parser #(
  parameter int QueueDepth = gcpp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  gcpp_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output gcpp_pkg::res_t  res
);
  import gcpp_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  gcpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  gcpp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_item)
  );

  gcpp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

@@ test/gpu_command_packet_parser_tb.sv @@
// ----------------------------------------------------------------------------
// gpu_command_packet_parser_tb
// Drives command-port words and parser resets into the packet parser and
// checks each result against an in-bench packet decoder model or a pinned row.
// A short table covers single-word commands, invalid opcodes, a flat
// triangle, a textured triangle, a polyline with an early terminator pattern
// and a reset in the middle of a packet. Random packets, broken packets,
// long polylines and noise follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
module gpu_command_packet_parser_tb;
  import gcpp_pkg::*;

  localparam int DIR_ROWS    = 25;
  localparam int RAND_ITEMS  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 1_000_000;

  typedef struct packed {
    cmd_t c;
    logic pinned;
    res_t want;
  } row_t;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;

  row_t pin_q[$];
  res_t tag_q[$];
  row_t dir_rows[DIR_ROWS];

  logic [7:0] line_opc[7] = '{8'h40, 8'h42, 8'h48, 8'h4A, 8'h50, 8'h52, 8'h58};
  logic [7:0] poly_opc[3] = '{8'h48, 8'h4A, 8'h58};

  // decoder state
  logic       pk_open = 1'b0;
  logic [7:0] pk_opc  = 8'h00;
  logic [4:0] pk_idx  = 5'd0;
  logic [3:0] pk_vtx  = 4'd0;

  bit calm;
  bit hold_req;
  int n_sent;
  int n_checked;
  int n_ends;
  int n_terms;
  int n_err;

  gpu_command_packet_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit has_tex(input logic [7:0] o);
    return (o < 8'h40) && o[2];
  endfunction

  function automatic int unsigned words_in_packet(input logic [7:0] o);
    int unsigned nv;
    nv = (o >= 8'h40) ? 2 : (o[3] ? 4 : 3);
    if (o[4]) return has_tex(o) ? 3 * nv : 2 * nv;
    return has_tex(o) ? 2 * nv + 1 : nv + 1;
  endfunction

  function automatic role_t word_kind(input logic [7:0] o, input int unsigned i,
                                      output bit ends_vtx);
    ends_vtx = 1'b0;
    if (i == 0) return ROLE_CMD;
    if (!o[4]) begin
      if (!has_tex(o)) begin
        ends_vtx = 1'b1;
        return ROLE_VERTEX;
      end
      if ((i - 1) % 2 == 0) return ROLE_VERTEX;
      ends_vtx = 1'b1;
      return (i == 2) ? ROLE_TEX_CLUT : ((i == 4) ? ROLE_TEX_PAGE : ROLE_TEX);
    end
    if (!has_tex(o)) begin
      if (i % 2 == 0) return ROLE_COLOR;
      ends_vtx = 1'b1;
      return ROLE_VERTEX;
    end
    if (i % 3 == 0) return ROLE_COLOR;
    if (i % 3 == 1) return ROLE_VERTEX;
    ends_vtx = 1'b1;
    return (i == 2) ? ROLE_TEX_CLUT : ((i == 5) ? ROLE_TEX_PAGE : ROLE_TEX);
  endfunction

  function automatic res_t predict_word(input cmd_t c);
    res_t        r;
    logic [7:0]  o;
    int unsigned i;
    bit          ends_vtx;
    r = '0;
    if (c.op == OP_RESET) begin
      pk_open = 1'b0;
      pk_opc  = 8'h00;
      pk_idx  = 5'd0;
      pk_vtx  = 4'd0;
      return r;
    end
    o = c.word[31:24];
    if (!pk_open) begin
      r.payload    = c.word;
      r.packet_end = 1'b1;
      if (o == 8'h00) begin
        r.word_role = ROLE_NOP;
        return r;
      end
      if (o == 8'h1F) begin
        r.word_role = ROLE_IRQ;
        return r;
      end
      if (o >= 8'hE1 && o <= 8'hE6) begin
        r.word_role      = ROLE_SETTING;
        r.payload        = {8'h00, c.word[23:0]};
        r.setting_target = 3'(o - 8'hE1);
        return r;
      end
      if (!((o >= 8'h20 && o <= 8'h3F) || o == 8'h40 || o == 8'h42 || o == 8'h48 ||
            o == 8'h4A || o == 8'h50 || o == 8'h52 || o == 8'h58)) begin
        r.word_role = ROLE_INVALID;
        return r;
      end
      r.packet_end = 1'b0;
      pk_open = 1'b1;
      pk_opc  = o;
      pk_idx  = 5'd0;
      pk_vtx  = 4'd0;
    end
    o = pk_opc;
    i = pk_idx;
    if (o < 8'h40) r.primitive_res = o[3] ? PRIM_QUAD : PRIM_TRI;
    else r.primitive_res = o[3] ? PRIM_POLY : PRIM_LINE;
    r.gouraud          = o[4];
    r.textured         = has_tex(o);
    r.raw_texture      = has_tex(o) & o[0];
    r.semi_transparent = o[1];
    r.vertex_number    = pk_vtx;
    r.payload          = c.word;
    if (o >= 8'h40 && o[3]) begin
      if (i >= 3 && (c.word & TERM_MASK) == TERM_VALUE) begin
        r.word_role  = ROLE_TERM;
        r.packet_end = 1'b1;
        pk_open = 1'b0;
        pk_idx  = 5'd0;
        pk_vtx  = 4'd0;
        return r;
      end
      r.word_role = word_kind(o, i, ends_vtx);
      if (ends_vtx && pk_vtx != 4'd15) pk_vtx = pk_vtx + 4'd1;
      pk_idx = (i == 31) ? 5'd30 : 5'(i + 1);
      return r;
    end
    r.word_role = word_kind(o, i, ends_vtx);
    if (ends_vtx && pk_vtx != 4'd15) pk_vtx = pk_vtx + 4'd1;
    if (i + 1 >= words_in_packet(o)) begin
      r.packet_end = 1'b1;
      pk_open = 1'b0;
      pk_idx  = 5'd0;
      pk_vtx  = 4'd0;
    end else begin
      pk_idx = 5'(i + 1);
    end
    return r;
  endfunction

  function automatic res_t lone_word(input role_t rl, input logic [31:0] pl,
                                     input logic [2:0] tg);
    res_t r;
    r                = '0;
    r.word_role      = rl;
    r.payload        = pl;
    r.setting_target = tg;
    r.packet_end     = (rl != ROLE_IDLE);
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  task automatic offer(input row_t rw);
    int g;
    g = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (g > 0) begin
      cmd_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pin_q.push_back(rw);
    cmd_valid <= 1'b1;
    cmd       <= rw.c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_cmd(input logic op_bit, input logic [31:0] w);
    row_t rw;
    rw        = '0;
    rw.c.op   = op_bit;
    rw.c.word = w;
    offer(rw);
  endtask

  task automatic send_poly(input logic [7:0] o, input int nbody, input bit early);
    logic [31:0] w;
    send_cmd(OP_WRITE, {o, 24'($urandom)});
    for (int k = 1; k <= nbody; k++) begin
      w = $urandom;
      if (k < 3 && early) w = (w & ~TERM_MASK) | TERM_VALUE;
      else if ((w & TERM_MASK) == TERM_VALUE) w = w ^ 32'h1000_0000;
      send_cmd(OP_WRITE, w);
    end
    send_cmd(OP_WRITE, (32'($urandom) & ~TERM_MASK) | TERM_VALUE);
  endtask

  task automatic wait_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (tag_q.size() != 0);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall     = 0;
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        res_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES - 1;
        res_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall = gap_len() - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : mon
    row_t rw;
    res_t want;
    res_t got;
    bit   bad;
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        rw   = pin_q[0];
        pin_q.delete(0);
        want = predict_word(rw.c);
        tag_q.push_back(rw.pinned ? rw.want : want);
      end
      if (res_valid && res_ready) begin
        got = res;
        if (tag_q.size() == 0) begin
          $error("result transfer with nothing expected: role %0d payload %h",
                 got.word_role, got.payload);
          n_err++;
        end else begin
          want = tag_q[0];
          tag_q.delete(0);
          bad  = 1'b0;
          if (got.word_role !== want.word_role) begin
            $error("word_role: expected %0d, got %0d", want.word_role, got.word_role);
            bad = 1'b1;
          end
          if (got.primitive_res !== want.primitive_res) begin
            $error("primitive_res: expected %0d, got %0d", want.primitive_res,
                   got.primitive_res);
            bad = 1'b1;
          end
          if (got.gouraud !== want.gouraud) begin
            $error("gouraud: expected %0d, got %0d", want.gouraud, got.gouraud);
            bad = 1'b1;
          end
          if (got.textured !== want.textured) begin
            $error("textured: expected %0d, got %0d", want.textured, got.textured);
            bad = 1'b1;
          end
          if (got.raw_texture !== want.raw_texture) begin
            $error("raw_texture: expected %0d, got %0d", want.raw_texture, got.raw_texture);
            bad = 1'b1;
          end
          if (got.semi_transparent !== want.semi_transparent) begin
            $error("semi_transparent: expected %0d, got %0d", want.semi_transparent,
                   got.semi_transparent);
            bad = 1'b1;
          end
          if (got.vertex_number !== want.vertex_number) begin
            $error("vertex_number: expected %0d, got %0d", want.vertex_number,
                   got.vertex_number);
            bad = 1'b1;
          end
          if (got.payload !== want.payload) begin
            $error("payload: expected %h, got %h", want.payload, got.payload);
            bad = 1'b1;
          end
          if (got.setting_target !== want.setting_target) begin
            $error("setting_target: expected %0d, got %0d", want.setting_target,
                   got.setting_target);
            bad = 1'b1;
          end
          if (got.packet_end !== want.packet_end) begin
            $error("packet_end: expected %0d, got %0d", want.packet_end, got.packet_end);
            bad = 1'b1;
          end
          if (bad) n_err++;
          n_checked++;
          if (want.packet_end) n_ends++;
          if (want.word_role == ROLE_TERM) n_terms++;
        end
      end
    end
  end

  initial begin
    int          r;
    int          nw;
    int          scen;
    logic [7:0]  o;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;

    // single-word commands and invalid opcodes
    dir_rows[0]  = '{'{OP_RESET, 32'hFFFF_FFFF}, 1'b1, lone_word(ROLE_IDLE, 32'h0, 3'd0)};
    dir_rows[1]  = '{'{OP_WRITE, 32'h0000_0000}, 1'b1,
                     lone_word(ROLE_NOP, 32'h0000_0000, 3'd0)};
    dir_rows[2]  = '{'{OP_WRITE, 32'h1F00_0000}, 1'b1,
                     lone_word(ROLE_IRQ, 32'h1F00_0000, 3'd0)};
    dir_rows[3]  = '{'{OP_WRITE, 32'hE1FF_FFFF}, 1'b1,
                     lone_word(ROLE_SETTING, 32'h00FF_FFFF, 3'd0)};
    dir_rows[4]  = '{'{OP_WRITE, 32'hE600_0000}, 1'b1,
                     lone_word(ROLE_SETTING, 32'h0000_0000, 3'd5)};
    dir_rows[5]  = '{'{OP_WRITE, 32'h5A12_3456}, 1'b1,
                     lone_word(ROLE_INVALID, 32'h5A12_3456, 3'd0)};
    dir_rows[6]  = '{'{OP_WRITE, 32'hFFFF_FFFF}, 1'b1,
                     lone_word(ROLE_INVALID, 32'hFFFF_FFFF, 3'd0)};
    dir_rows[7]  = '{'{OP_WRITE, 32'h41AB_CDEF}, 1'b1,
                     lone_word(ROLE_INVALID, 32'h41AB_CDEF, 3'd0)};
    // flat triangle
    dir_rows[8]  = '{'{OP_WRITE, 32'h20FF_00FF}, 1'b0, '0};
    dir_rows[9]  = '{'{OP_WRITE, 32'h0000_0000}, 1'b0, '0};
    dir_rows[10] = '{'{OP_WRITE, 32'hFFFF_FFFF}, 1'b0, '0};
    dir_rows[11] = '{'{OP_WRITE, 32'h7FFF_8000}, 1'b0, '0};
    // flat textured triangle with clut and page words
    dir_rows[12] = '{'{OP_WRITE, 32'h2480_8080}, 1'b0, '0};
    dir_rows[13] = '{'{OP_WRITE, 32'h0001_0002}, 1'b0, '0};
    dir_rows[14] = '{'{OP_WRITE, 32'h7FFF_0000}, 1'b0, '0};
    dir_rows[15] = '{'{OP_WRITE, 32'h8000_FFFF}, 1'b0, '0};
    dir_rows[16] = '{'{OP_WRITE, 32'hFFFF_FFFF}, 1'b0, '0};
    dir_rows[17] = '{'{OP_WRITE, 32'h0000_0000}, 1'b0, '0};
    dir_rows[18] = '{'{OP_WRITE, 32'h1234_5678}, 1'b0, '0};
    // polyline, terminator pattern too early, then a real terminator
    dir_rows[19] = '{'{OP_WRITE, 32'h4800_0000}, 1'b0, '0};
    dir_rows[20] = '{'{OP_WRITE, 32'h1111_1111}, 1'b0, '0};
    dir_rows[21] = '{'{OP_WRITE, 32'h5000_5000}, 1'b0, '0};
    dir_rows[22] = '{'{OP_WRITE, 32'h5FFF_5FFF}, 1'b0, '0};
    // reset drops a partial gouraud textured packet
    dir_rows[23] = '{'{OP_WRITE, 32'h3E00_0000}, 1'b0, '0};
    dir_rows[24] = '{'{OP_RESET, 32'h0000_0000}, 1'b1, lone_word(ROLE_IDLE, 32'h0, 3'd0)};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) offer(dir_rows[i]);

    scen = 0;
    while (n_sent < DIR_ROWS + RAND_ITEMS) begin
      if (scen == 100) begin
        hold_req = 1'b1;
        calm     = 1'b1;
      end
      if (scen == 130) calm = 1'b0;
      if (scen == 200) wait_results();
      if (scen == 260) calm = 1'b1;
      if (scen == 300) calm = 1'b0;
      scen++;

      r = $urandom_range(0, 38);
      o = (r < 32) ? 8'(32'h20 + r) : line_opc[r - 32];
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if (o >= 8'h40 && o[3]) begin
          send_poly(o, $urandom_range(2, 8), 1'b0);
        end else begin
          send_cmd(OP_WRITE, {o, 24'($urandom)});
          repeat (words_in_packet(o) - 1) send_cmd(OP_WRITE, $urandom);
        end
      end else if (r < 62) begin
        send_poly(poly_opc[$urandom_range(0, 2)], $urandom_range(2, 5), 1'b1);
      end else if (r < 65) begin
        send_poly(poly_opc[$urandom_range(0, 2)], $urandom_range(30, 40), 1'b0);
      end else if (r < 77) begin
        nw = $urandom_range(0, 7);
        if (nw == 0) send_cmd(OP_WRITE, {8'h00, 24'($urandom)});
        else if (nw == 1) send_cmd(OP_WRITE, {8'h1F, 24'($urandom)});
        else send_cmd(OP_WRITE, {8'(8'hE1 + nw - 2), 24'($urandom)});
      end else if (r < 85) begin
        nw = $urandom_range(0, words_in_packet(o) - 2);
        send_cmd(OP_WRITE, {o, 24'($urandom)});
        repeat (nw) send_cmd(OP_WRITE, $urandom);
        send_cmd(OP_RESET, $urandom);
      end else begin
        send_cmd(($urandom_range(0, 9) == 0) ? OP_RESET : OP_WRITE, $urandom);
      end
    end

    wait_results();
    repeat (12) @(posedge clk);

    $display("covered %0d transfers: table, full and broken packets, long polylines,",
             n_sent);
    $display("  resets, receiver hold-off and drain; %0d results, %0d ends, %0d terminators",
             n_checked, n_ends, n_terms);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
